// ===== rtl/core/goc_pkg.sv =====
`timescale 1ns / 1ps

package goc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int EXP_BITS    = 8;
	localparam int GRAD_SHIFT  = 24;
	localparam int M_CLAMP_INT = 64;
	localparam int MC_W        = FRAC_BITS + 7;
	localparam int TP_W        = MC_W + 30;
	localparam int TI_W        = 6;
	localparam int CFG_IDX_W   = 3;

	localparam logic [29:0]       HALF_LOG2E = 30'd774541002;
	localparam logic [MC_W-1:0]   M_CLAMP    = MC_W'(M_CLAMP_INT << FRAC_BITS);
	localparam logic [TI_W-1:0]   TI_RUNOUT  = TI_W'(32);
	localparam logic [31:0]       ONE_COORD  = 32'(1 << FRAC_BITS);

	// 2^-(2^-k) in Q0.32, k = 1 upward
	localparam logic [31:0] POW2_NEG [12] = '{
		32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
		32'd4202935003, 32'd4248701965, 32'd4271771997, 32'd4283353945,
		32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540
	};

	localparam logic [CFG_IDX_W-1:0] REG_MEAN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_COV_XX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_COV_XY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_COV_YY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NORM       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd6;

	typedef struct packed {
		logic signed [31:0] mean_x;
		logic signed [31:0] mean_y;
		logic signed [31:0] inv_cov_xx;
		logic signed [31:0] inv_cov_xy;
		logic signed [31:0] inv_cov_yy;
		logic [31:0]        norm_factor;
		logic [31:0]        radius;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               feasible;
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic [MC_W-1:0]    mc;
	} quad_t;

	typedef struct packed {
		logic                valid;
		logic                feasible;
		logic signed [31:0]  wx;
		logic signed [31:0]  wy;
		logic [TI_W-1:0]     ti;
		logic [EXP_BITS-1:0] idx;
		logic                one;
		logic [31:0]         acc;
	} exp_t;

	typedef struct packed {
		logic               valid;
		logic [31:0]        cost;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic               feasible;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi)
			return 32'sh7fffffff;
		else if (v < lo)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ===== rtl/core/goc_quad.sv =====
`timescale 1ns / 1ps

module goc_quad (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic signed [31:0]  query_x,
	input  logic signed [31:0]  query_y,
	input  goc_pkg::cfg_t       cfg,
	output goc_pkg::quad_t      q_out
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [32:0] dx_c, dy_c;
	logic [31:0]        ax_c, ay_c;

	logic signed [31:0] ex_s1, ey_s1;
	logic [31:0]        ax_s1, ay_s1;

	logic signed [63:0] pxx_s2, pxy_s2, pyx_s2, pyy_s2;
	logic [63:0]        ax2_s2, ay2_s2, r2_s2;
	logic signed [31:0] ex_s2, ey_s2;

	logic signed [48:0] swx_c, swy_c;
	logic signed [31:0] wx_s3, wy_s3, ex_s3, ey_s3;
	logic               feas_s3;

	logic signed [63:0] mx_s4, my_s4;
	logic signed [31:0] wx_s4, wy_s4;
	logic               feas_s4;

	logic signed [48:0]        m_c;
	logic [goc_pkg::MC_W-1:0]  mc_c;
	logic [goc_pkg::MC_W-1:0]  mc_s5;
	logic signed [31:0]        wx_s5, wy_s5;
	logic                      feas_s5;

	assign dx_c = $signed({query_x[31], query_x}) - $signed({cfg.mean_x[31], cfg.mean_x});
	assign dy_c = $signed({query_y[31], query_y}) - $signed({cfg.mean_y[31], cfg.mean_y});
	assign ax_c = dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
	assign ay_c = dy_c[32] ? 32'(-dy_c) : dy_c[31:0];

	assign swx_c = 49'(pxx_s2 >>> goc_pkg::FRAC_BITS) + 49'(pxy_s2 >>> goc_pkg::FRAC_BITS);
	assign swy_c = 49'(pyx_s2 >>> goc_pkg::FRAC_BITS) + 49'(pyy_s2 >>> goc_pkg::FRAC_BITS);

	assign m_c = 49'(mx_s4 >>> goc_pkg::FRAC_BITS) + 49'(my_s4 >>> goc_pkg::FRAC_BITS);

	always_comb begin
		if (m_c < 0)
			mc_c = '0;
		else if (m_c > 49'(goc_pkg::M_CLAMP))
			mc_c = goc_pkg::M_CLAMP;
		else
			mc_c = m_c[goc_pkg::MC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s1   <= goc_pkg::sat32(66'(dx_c));
			ey_s1   <= goc_pkg::sat32(66'(dy_c));
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;

			pxx_s2  <= cfg.inv_cov_xx * ex_s1;
			pxy_s2  <= cfg.inv_cov_xy * ey_s1;
			pyx_s2  <= cfg.inv_cov_xy * ex_s1;
			pyy_s2  <= cfg.inv_cov_yy * ey_s1;
			ax2_s2  <= 64'(ax_s1) * 64'(ax_s1);
			ay2_s2  <= 64'(ay_s1) * 64'(ay_s1);
			r2_s2   <= 64'(cfg.radius) * 64'(cfg.radius);
			ex_s2   <= ex_s1;
			ey_s2   <= ey_s1;

			wx_s3   <= goc_pkg::sat32(66'(swx_c));
			wy_s3   <= goc_pkg::sat32(66'(swy_c));
			ex_s3   <= ex_s2;
			ey_s3   <= ey_s2;
			feas_s3 <= (65'(ax2_s2) + 65'(ay2_s2)) >= 65'(r2_s2);

			mx_s4   <= ex_s3 * wx_s3;
			my_s4   <= ey_s3 * wy_s3;
			wx_s4   <= wx_s3;
			wy_s4   <= wy_s3;
			feas_s4 <= feas_s3;

			mc_s5   <= mc_c;
			wx_s5   <= wx_s4;
			wy_s5   <= wy_s4;
			feas_s5 <= feas_s4;
		end
	end

	assign q_out = '{valid: v_s5, feasible: feas_s5, wx: wx_s5, wy: wy_s5, mc: mc_s5};

endmodule

// ===== rtl/core/goc_exp.sv =====
`timescale 1ns / 1ps

module goc_exp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  goc_pkg::quad_t q_in,
	output goc_pkg::exp_t  e_out
);

	logic [goc_pkg::EXP_BITS:0]  vld_s;
	goc_pkg::exp_t               stg_s [goc_pkg::EXP_BITS+1];
	logic [goc_pkg::TP_W-1:0]    tp_c;
	logic [goc_pkg::MC_W-1:0]    t_c;

	// t = mc * log2(e)/2, integer part is the shift, top fraction bits the table index
	assign tp_c = goc_pkg::TP_W'(q_in.mc) * goc_pkg::TP_W'(goc_pkg::HALF_LOG2E);
	assign t_c  = tp_c[goc_pkg::TP_W-1:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[goc_pkg::EXP_BITS-1:0], q_in.valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s[0] <= '{
				valid:    1'b0,
				feasible: q_in.feasible,
				wx:       q_in.wx,
				wy:       q_in.wy,
				ti:       t_c[goc_pkg::FRAC_BITS +: goc_pkg::TI_W],
				idx:      t_c[goc_pkg::FRAC_BITS-1 -: goc_pkg::EXP_BITS],
				one:      1'b1,
				acc:      '0
			};
		end
	end

	genvar k;
	for (k = 1; k <= goc_pkg::EXP_BITS; k++) begin : g_step
		logic [63:0]   pr_c;
		goc_pkg::exp_t nx_c;

		always_comb begin
			nx_c = stg_s[k-1];
			pr_c = 64'(stg_s[k-1].acc) * 64'(goc_pkg::POW2_NEG[k-1]) + 64'h8000_0000;
			if (stg_s[k-1].idx[goc_pkg::EXP_BITS-k]) begin
				if (stg_s[k-1].one) begin
					nx_c.acc = goc_pkg::POW2_NEG[k-1];
					nx_c.one = 1'b0;
				end else begin
					nx_c.acc = pr_c[63:32];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				stg_s[k] <= nx_c;
		end
	end

	always_comb begin
		e_out       = stg_s[goc_pkg::EXP_BITS];
		e_out.valid = vld_s[goc_pkg::EXP_BITS];
	end

endmodule

// ===== rtl/core/goc_grad.sv =====
`timescale 1ns / 1ps

module goc_grad (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic [31:0]   norm_factor,
	input  goc_pkg::exp_t e_in,
	output goc_pkg::res_t r_out
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic [63:0]                prod_s1;
	logic [goc_pkg::TI_W-1:0]   ti_s1;
	logic signed [31:0]         wx_s1, wy_s1;
	logic                       feas_s1;

	logic [31:0]                cost_s2;
	logic signed [31:0]         wx_s2, wy_s2;
	logic                       feas_s2;

	logic signed [64:0]         px_s3, py_s3;
	logic [31:0]                cost_s3;
	logic                       feas_s3;

	logic signed [65:0]         nx_c, ny_c;
	logic [31:0]                cost_s4;
	logic signed [31:0]         gx_s4, gy_s4;
	logic                       feas_s4;

	assign nx_c = -66'(px_s3);
	assign ny_c = -66'(py_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= e_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= e_in.one ? {norm_factor, 32'b0} : 64'(norm_factor) * 64'(e_in.acc);
			ti_s1   <= e_in.ti;
			wx_s1   <= e_in.wx;
			wy_s1   <= e_in.wy;
			feas_s1 <= e_in.feasible;

			// shift of 32 + ti runs out at 64
			cost_s2 <= (ti_s1 >= goc_pkg::TI_RUNOUT) ? 32'd0
			           : 32'(prod_s1 >> (7'd32 + 7'(ti_s1)));
			wx_s2   <= wx_s1;
			wy_s2   <= wy_s1;
			feas_s2 <= feas_s1;

			px_s3   <= $signed({1'b0, cost_s2}) * wx_s2;
			py_s3   <= $signed({1'b0, cost_s2}) * wy_s2;
			cost_s3 <= cost_s2;
			feas_s3 <= feas_s2;

			gx_s4   <= goc_pkg::sat32(nx_c >>> goc_pkg::GRAD_SHIFT);
			gy_s4   <= goc_pkg::sat32(ny_c >>> goc_pkg::GRAD_SHIFT);
			cost_s4 <= cost_s3;
			feas_s4 <= feas_s3;
		end
	end

	assign r_out = '{valid: v_s4, cost: cost_s4, grad_x: gx_s4, grad_y: gy_s4,
	                 feasible: feas_s4};

endmodule

// ===== rtl/core/gaussian_obstacle_cost_unit.sv =====
`timescale 1ns / 1ps

// channel   signals                                          direction
// input     in_valid, in_ready, query_x, query_y             in
// result    out_valid, out_ready, cost, grad_x, grad_y,      out
//           feasible
// config    cfg_we, cfg_index, cfg_data                      in, write only
//
// One item per cycle when not stalled; stages: quadratic form, exp, cost/gradient.
// The pipeline advances as a whole; the last stage is the output register.
// A stalled result holds every stage, nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults; no clearing pass.

module gaussian_obstacle_cost_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [31:0]                query_x,
	input  logic signed [31:0]                query_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       cost,
	output logic signed [31:0]                grad_x,
	output logic signed [31:0]                grad_y,
	output logic                              feasible,
	input  logic                              cfg_we,
	input  logic [goc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	goc_pkg::cfg_t  cfg_q;
	goc_pkg::quad_t quad;
	goc_pkg::exp_t  expo;
	goc_pkg::res_t  res;
	logic           adv;

	assign adv      = !res.valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_x      <= '0;
			cfg_q.mean_y      <= '0;
			cfg_q.inv_cov_xx  <= goc_pkg::ONE_COORD;
			cfg_q.inv_cov_xy  <= '0;
			cfg_q.inv_cov_yy  <= goc_pkg::ONE_COORD;
			cfg_q.norm_factor <= '0;
			cfg_q.radius      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				goc_pkg::REG_MEAN_X:     cfg_q.mean_x      <= cfg_data;
				goc_pkg::REG_MEAN_Y:     cfg_q.mean_y      <= cfg_data;
				goc_pkg::REG_INV_COV_XX: cfg_q.inv_cov_xx  <= cfg_data;
				goc_pkg::REG_INV_COV_XY: cfg_q.inv_cov_xy  <= cfg_data;
				goc_pkg::REG_INV_COV_YY: cfg_q.inv_cov_yy  <= cfg_data;
				goc_pkg::REG_NORM:       cfg_q.norm_factor <= cfg_data;
				goc_pkg::REG_RADIUS:     cfg_q.radius      <= cfg_data;
				default: ;
			endcase
		end
	end

	goc_quad u_quad (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.query_x  (query_x),
		.query_y  (query_y),
		.cfg      (cfg_q),
		.q_out    (quad)
	);

	goc_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.q_in   (quad),
		.e_out  (expo)
	);

	goc_grad u_grad (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.norm_factor (cfg_q.norm_factor),
		.e_in        (expo),
		.r_out       (res)
	);

	assign out_valid = res.valid;
	assign cost      = res.cost;
	assign grad_x    = res.grad_x;
	assign grad_y    = res.grad_y;
	assign feasible  = res.feasible;

endmodule

// ===== rtl/core/goc_checker.sv =====
`timescale 1ns / 1ps

module goc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [31:0]        cost,
	input logic signed [31:0] grad_x,
	input logic signed [31:0] grad_y,
	input logic               feasible
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cost) && $stable(grad_x)
			&& $stable(grad_y) && $stable(feasible))
		else $error("stalled item changed");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while pipeline stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline not ready with empty output");

	a_zero_grad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cost == 32'd0 |-> grad_x == 32'sd0 && grad_y == 32'sd0)
		else $error("nonzero gradient with zero cost");

endmodule

bind gaussian_obstacle_cost_unit goc_checker u_goc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.cost      (cost),
	.grad_x    (grad_x),
	.grad_y    (grad_y),
	.feasible  (feasible)
);
